// ===== hw/rtl/nau_pkg.sv =====
// ----------------------------------------------------------------------------
// nau_pkg: shared types and constants of the activation unit
// Word formats, fixed-point sizes and the constants of the exponential.
// ----------------------------------------------------------------------------
package nau_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 12;
  localparam int EXP_TERMS   = 16;
  localparam int EXP_CUTOFF  = 24;

  // Magnitude doubled for tanh needs one more bit than the sample.
  localparam int T_W         = DATA_WIDTH + 1;
  localparam int N_W         = T_W - FRAC_BITS;
  // Q32 values up to and including 1.0.
  localparam int E_W         = 33;
  localparam int SUM_W       = 35;
  localparam int DEN_W       = 34;
  localparam int REM_W       = DEN_W + FRAC_BITS;
  localparam int DIV_Q_W     = FRAC_BITS + 1;
  localparam int POW_MAX     = 2 ** (DATA_WIDTH - FRAC_BITS);
  localparam int POW_STAGES  = (POW_MAX < EXP_CUTOFF - 1) ? POW_MAX : EXP_CUTOFF - 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [E_W-1:0] Q32_ONE = E_W'(1) << 32;

  localparam logic [1:0] MODE_RELU    = 2'd0;
  localparam logic [1:0] MODE_SIGMOID = 2'd1;
  localparam logic [1:0] MODE_TANH    = 2'd2;

  // Series value of e^-0.5 in Q32, evaluated once at elaboration.
  function automatic logic [63:0] exp_neg_half_q32();
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 32;
    sum  = 64'd1 << 32;
    for (int k = 1; k <= EXP_TERMS; k++) begin
      term = ((term << 31) + (64'd1 << 31)) >> 32;
      term = term / 64'(k);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  localparam logic [63:0] E_HALF     = exp_neg_half_q32();
  localparam logic [63:0] E_ONE_FULL = ((E_HALF * E_HALF) + (64'd1 << 31)) >> 32;
  localparam logic [31:0] E_NEG_ONE  = E_ONE_FULL[31:0];

  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_SIG  = 2'd1,
    OP_TANH = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]                   mode;
    logic signed [DATA_WIDTH-1:0] sample;
    logic                         last;
  } nau_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] activated;
    logic                         last_out;
  } nau_out_t;

  typedef struct packed {
    op_t                          op;
    logic                         neg;
    logic [N_W-1:0]               n;
    logic                         zero;
    logic signed [DATA_WIDTH-1:0] pass;
    logic                         last;
  } ctl_t;

  typedef struct packed {
    ctl_t                 ctl;
    logic [FRAC_BITS-1:0] f;
  } cls_t;

endpackage

// ===== hw/rtl/nau_front.sv =====
// ----------------------------------------------------------------------------
// nau_front: input classification
// Decodes the mode, takes the magnitude and splits the exponent argument.
// ----------------------------------------------------------------------------
module nau_front (
  input  nau_pkg::nau_in_t in_word,
  output nau_pkg::cls_t    cls
);
  import nau_pkg::*;

  logic                         neg;
  logic [DATA_WIDTH-1:0]        mag;
  logic [T_W-1:0]               t;
  logic signed [DATA_WIDTH-1:0] x;

  always_comb begin
    x   = in_word.sample;
    neg = x[DATA_WIDTH-1];
    mag = neg ? (~x + DATA_WIDTH'(1)) : x;
    t   = {1'b0, mag};
    cls = '0;
    cls.ctl.neg  = neg;
    cls.ctl.last = in_word.last;
    unique case (in_word.mode)
      MODE_RELU: begin
        cls.ctl.op   = OP_PASS;
        cls.ctl.pass = neg ? '0 : x;
      end
      MODE_SIGMOID: begin
        cls.ctl.op = OP_SIG;
      end
      MODE_TANH: begin
        cls.ctl.op = OP_TANH;
        t          = {mag, 1'b0};
      end
      default: begin
        cls.ctl.op   = OP_PASS;
        cls.ctl.pass = x;
      end
    endcase
    cls.ctl.n    = t[T_W-1:FRAC_BITS];
    cls.ctl.zero = (t[T_W-1:FRAC_BITS] >= N_W'(EXP_CUTOFF));
    cls.f        = t[FRAC_BITS-1:0];
  end

endmodule

// ===== hw/rtl/nau_fifo.sv =====
// ----------------------------------------------------------------------------
// nau_fifo: short queue between the front and the back
// Holds classified words so that either side can stall on its own.
// ----------------------------------------------------------------------------
module nau_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  nau_pkg::cls_t wdata,
  output logic          q_full,
  input  logic          rd,
  output nau_pkg::cls_t rdata,
  output logic          q_empty
);
  import nau_pkg::*;

  cls_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = rd ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(wr) - QCNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/nau_exp.sv =====
// ----------------------------------------------------------------------------
// nau_exp: pipelined exponential e^-t in Q32
// Series for the fraction (two stages a term), then one stage per unit step.
// ----------------------------------------------------------------------------
module nau_exp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  nau_pkg::cls_t            in_cls,
  output logic                     out_vld,
  output nau_pkg::ctl_t            out_ctl,
  output logic [nau_pkg::E_W-1:0]  out_e
);
  import nau_pkg::*;

  localparam int PROD_W = E_W + FRAC_BITS + 1;

  logic                    s_vld   [EXP_TERMS];
  ctl_t                    s_ctl   [EXP_TERMS];
  logic [FRAC_BITS-1:0]    s_f     [EXP_TERMS];
  logic [E_W-1:0]          s_term  [EXP_TERMS];
  logic signed [SUM_W-1:0] s_sum   [EXP_TERMS];

  logic                    a_vld_r [EXP_TERMS];
  ctl_t                    a_ctl_r [EXP_TERMS];
  logic [FRAC_BITS-1:0]    a_f_r   [EXP_TERMS];
  logic [31:0]             a_p_r   [EXP_TERMS];
  logic signed [SUM_W-1:0] a_sum_r [EXP_TERMS];

  logic                    b_vld_r [EXP_TERMS];
  ctl_t                    b_ctl_r [EXP_TERMS];
  logic [FRAC_BITS-1:0]    b_f_r   [EXP_TERMS];
  logic [E_W-1:0]          b_term_r[EXP_TERMS];
  logic signed [SUM_W-1:0] b_sum_r [EXP_TERMS];

  logic                    p_in_vld[POW_STAGES];
  ctl_t                    p_in_ctl[POW_STAGES];
  logic [E_W-1:0]          p_in_e  [POW_STAGES];
  logic                    p_vld_r [POW_STAGES];
  ctl_t                    p_ctl_r [POW_STAGES];
  logic [E_W-1:0]          p_e_r   [POW_STAGES];

  genvar j;
  generate
    for (j = 0; j < EXP_TERMS; j++) begin : g_term
      localparam int K = j + 1;
      localparam int L = $clog2(K);
      localparam logic [64:0] M_FULL = ((65'd1 << (32 + L)) + 65'(K - 1)) / 65'(K);
      localparam logic [32:0] M      = M_FULL[32:0];

      logic [PROD_W-1:0] prod;
      logic [64:0]       qprod;
      logic [E_W-1:0]    q;

      if (j == 0) begin : g_src0
        assign s_vld[j]  = in_vld;
        assign s_ctl[j]  = in_cls.ctl;
        assign s_f[j]    = in_cls.f;
        assign s_term[j] = Q32_ONE;
        assign s_sum[j]  = SUM_W'(Q32_ONE);
      end else begin : g_srcn
        assign s_vld[j]  = b_vld_r[j-1];
        assign s_ctl[j]  = b_ctl_r[j-1];
        assign s_f[j]    = b_f_r[j-1];
        assign s_term[j] = b_term_r[j-1];
        assign s_sum[j]  = b_sum_r[j-1];
      end

      // Rounded product term * fraction, rounding half up at the fraction point.
      assign prod = (PROD_W'(s_term[j]) * PROD_W'(s_f[j]))
                    + (PROD_W'(1) << (FRAC_BITS - 1));

      // Truncating division by the term index through a reciprocal multiply.
      assign qprod = 65'(a_p_r[j]) * 65'(M);
      assign q     = E_W'(qprod >> (32 + L));

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          a_vld_r[j] <= 1'b0;
          b_vld_r[j] <= 1'b0;
        end else if (en) begin
          a_vld_r[j] <= s_vld[j];
          b_vld_r[j] <= a_vld_r[j];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          a_ctl_r[j]  <= s_ctl[j];
          a_f_r[j]    <= s_f[j];
          a_p_r[j]    <= prod[FRAC_BITS+31:FRAC_BITS];
          a_sum_r[j]  <= s_sum[j];
          b_ctl_r[j]  <= a_ctl_r[j];
          b_f_r[j]    <= a_f_r[j];
          b_term_r[j] <= q;
          if (K % 2 == 1) begin
            b_sum_r[j] <= a_sum_r[j] - $signed({2'b00, q});
          end else begin
            b_sum_r[j] <= a_sum_r[j] + $signed({2'b00, q});
          end
        end
      end
    end

    for (j = 0; j < POW_STAGES; j++) begin : g_pow
      logic [64:0] mprod;

      if (j == 0) begin : g_src0
        assign p_in_vld[j] = b_vld_r[EXP_TERMS-1];
        assign p_in_ctl[j] = b_ctl_r[EXP_TERMS-1];
        assign p_in_e[j]   = b_sum_r[EXP_TERMS-1][SUM_W-1] ? '0
                             : b_sum_r[EXP_TERMS-1][E_W-1:0];
      end else begin : g_srcn
        assign p_in_vld[j] = p_vld_r[j-1];
        assign p_in_ctl[j] = p_ctl_r[j-1];
        assign p_in_e[j]   = p_e_r[j-1];
      end

      assign mprod = (65'(p_in_e[j]) * 65'(E_NEG_ONE)) + (65'd1 << 31);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          p_vld_r[j] <= 1'b0;
        end else if (en) begin
          p_vld_r[j] <= p_in_vld[j];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          p_ctl_r[j] <= p_in_ctl[j];
          p_e_r[j]   <= (N_W'(j) < p_in_ctl[j].n) ? mprod[64:32] : p_in_e[j];
        end
      end
    end
  endgenerate

  assign out_vld = p_vld_r[POW_STAGES-1];
  assign out_ctl = p_ctl_r[POW_STAGES-1];
  assign out_e   = p_ctl_r[POW_STAGES-1].zero ? '0 : p_e_r[POW_STAGES-1];

endmodule

// ===== hw/rtl/nau_div.sv =====
// ----------------------------------------------------------------------------
// nau_div: quotient, sign and saturation
// Forms the ratio, divides one quotient bit a stage and registers the word.
// ----------------------------------------------------------------------------
module nau_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  nau_pkg::ctl_t           in_ctl,
  input  logic [nau_pkg::E_W-1:0] in_e,
  output logic                    out_vld,
  output nau_pkg::nau_out_t       out_word
);
  import nau_pkg::*;

  localparam int DIV_STAGES = FRAC_BITS + 1;
  localparam int Y_W        = DATA_WIDTH + 2;

  logic [E_W-1:0]     num;
  logic [DEN_W-1:0]   den;

  logic               su_vld_r;
  ctl_t               su_ctl_r;
  logic [DEN_W-1:0]   su_den_r;
  logic [REM_W-1:0]   su_rem_r;

  logic               d_in_vld [DIV_STAGES];
  ctl_t               d_in_ctl [DIV_STAGES];
  logic [DEN_W-1:0]   d_in_den [DIV_STAGES];
  logic [REM_W-1:0]   d_in_rem [DIV_STAGES];
  logic [DIV_Q_W-1:0] d_in_q   [DIV_STAGES];

  logic               d_vld_r  [DIV_STAGES];
  ctl_t               d_ctl_r  [DIV_STAGES];
  logic [DEN_W-1:0]   d_den_r  [DIV_STAGES];
  logic [REM_W-1:0]   d_rem_r  [DIV_STAGES];
  logic [DIV_Q_W-1:0] d_q_r    [DIV_STAGES];

  logic signed [Y_W-1:0] y;
  logic                  out_vld_r;
  nau_out_t              out_r, out_nxt;
  ctl_t                  fin_ctl;

  always_comb begin
    den = DEN_W'(Q32_ONE) + DEN_W'(in_e);
    if (in_ctl.op == OP_TANH) begin
      num = Q32_ONE - in_e;
    end else begin
      num = in_ctl.neg ? in_e : Q32_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_vld_r <= 1'b0;
    end else if (en) begin
      su_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      su_ctl_r <= in_ctl;
      su_den_r <= den;
      su_rem_r <= (REM_W'(num) << FRAC_BITS) + REM_W'(den >> 1);
    end
  end

  genvar i;
  generate
    for (i = 0; i < DIV_STAGES; i++) begin : g_div
      localparam int B = FRAC_BITS - i;

      logic [REM_W:0] shifted;
      logic           ge;

      if (i == 0) begin : g_src0
        assign d_in_vld[i] = su_vld_r;
        assign d_in_ctl[i] = su_ctl_r;
        assign d_in_den[i] = su_den_r;
        assign d_in_rem[i] = su_rem_r;
        assign d_in_q[i]   = '0;
      end else begin : g_srcn
        assign d_in_vld[i] = d_vld_r[i-1];
        assign d_in_ctl[i] = d_ctl_r[i-1];
        assign d_in_den[i] = d_den_r[i-1];
        assign d_in_rem[i] = d_rem_r[i-1];
        assign d_in_q[i]   = d_q_r[i-1];
      end

      assign shifted = (REM_W + 1)'(d_in_den[i]) << B;
      assign ge      = ({1'b0, d_in_rem[i]} >= shifted);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          d_vld_r[i] <= 1'b0;
        end else if (en) begin
          d_vld_r[i] <= d_in_vld[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          d_ctl_r[i] <= d_in_ctl[i];
          d_den_r[i] <= d_in_den[i];
          d_rem_r[i] <= ge ? d_in_rem[i] - shifted[REM_W-1:0] : d_in_rem[i];
          d_q_r[i]   <= d_in_q[i] | (DIV_Q_W'(ge) << B);
        end
      end
    end
  endgenerate

  always_comb begin
    fin_ctl = d_ctl_r[DIV_STAGES-1];
    if (fin_ctl.op == OP_PASS) begin
      y = Y_W'(fin_ctl.pass);
    end else if (fin_ctl.op == OP_TANH && fin_ctl.neg) begin
      y = -$signed(Y_W'(d_q_r[DIV_STAGES-1]));
    end else begin
      y = $signed(Y_W'(d_q_r[DIV_STAGES-1]));
    end
    out_nxt.last_out = fin_ctl.last;
    if (y > $signed(Y_W'({1'b0, {(DATA_WIDTH-1){1'b1}}}))) begin
      out_nxt.activated = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else if (y < -$signed(Y_W'({1'b1, {(DATA_WIDTH-1){1'b0}}}))) begin
      out_nxt.activated = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      out_nxt.activated = y[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d_vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_word = out_r;

endmodule

// ===== hw/rtl/neural_activation_unit.sv =====
// ----------------------------------------------------------------------------
// neural_activation_unit: element-wise ReLU, sigmoid and tanh
// Top level joining the classifying front, the word queue and the back pipeline.
// ----------------------------------------------------------------------------
// The unit takes one Q4.12 word per clock while it is not full and returns
// one result word per clock while results are popped, in the same order,
// with the last marker copied across. ReLU clamps negative words to zero
// and the unused mode hands the word through unchanged; both still travel
// the full pipeline so that order is kept. Sigmoid and tanh are computed
// exactly as the integer series evaluation defines them, so results are
// bit-exact and lie within one LSB of the rounded true value. The edge that
// accepts a word writes it into the queue, and the head is then taken
// through the series evaluation (two stages a term), 16 stages of
// unit-step exponent multiplies, one set-up stage, 13 stages of restoring
// division (one quotient bit each) and the output register. The back
// pipeline moves as a whole, and halts only while a finished word waits at
// the output and is not popped; the four-word queue in front of it keeps
// the input side accepting through such short halts.
// ----------------------------------------------------------------------------
module neural_activation_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  nau_pkg::nau_in_t  in_word,
  output logic              empty,
  input  logic              pop,
  output nau_pkg::nau_out_t out_word
);
  import nau_pkg::*;

  cls_t                cls;
  cls_t                q_head;
  logic                q_empty;
  logic                q_rd;
  logic                back_en;
  logic                exp_vld;
  ctl_t                exp_ctl;
  logic [E_W-1:0]      exp_e;
  logic                out_vld;

  // The whole back pipeline steps when the output register is free or is
  // being emptied in this cycle.
  assign back_en = !out_vld || pop;
  assign q_rd    = back_en && !q_empty;
  assign empty   = !out_vld;

  nau_front u_front (
    .in_word (in_word),
    .cls     (cls)
  );

  nau_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (push && !full),
    .wdata   (cls),
    .q_full  (full),
    .rd      (q_rd),
    .rdata   (q_head),
    .q_empty (q_empty)
  );

  nau_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (back_en),
    .in_vld  (!q_empty),
    .in_cls  (q_head),
    .out_vld (exp_vld),
    .out_ctl (exp_ctl),
    .out_e   (exp_e)
  );

  nau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (back_en),
    .in_vld   (exp_vld),
    .in_ctl   (exp_ctl),
    .in_e     (exp_e),
    .out_vld  (out_vld),
    .out_word (out_word)
  );

endmodule

// ===== tb/sv/tb_neural_activation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_neural_activation_unit: self-checking bench for the activation unit
// Drives directed and random words through the push/full side under varied
// idling, predicts every result (sigmoid and tanh through an integer series
// evaluation of the exponential), and compares each popped word in order.
// ----------------------------------------------------------------------------
module tb_neural_activation_unit;
  import nau_pkg::*;

  localparam longint unsigned ONE_Q32  = 64'd1 << 32;
  localparam longint unsigned HALF_Q32 = 64'd1 << 31;

  logic     clk;
  logic     rst_n;
  logic     push;
  logic     full;
  nau_in_t  in_word;
  logic     empty;
  logic     pop;
  nau_out_t out_word;

  neural_activation_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

  // Words waiting to be pushed, and the results that accepted words must give.
  nau_in_t  pending_words[$];
  nau_out_t expected_results[$];
  int       error_count;
  // Idling rates, in percent, for the sender and the receiver.
  int       send_idle_pct;
  int       recv_stall_pct;
  // When set, the sender holds back until all expected results have come.
  logic     hold_send;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Q32 products rounded half up, as the series evaluation defines them.
  function automatic longint unsigned q32_mul(longint unsigned a, longint unsigned b);
    return (a * b + HALF_Q32) >> 32;
  endfunction

  // e^-r for a Q32 fraction r by a sixteen-term Taylor series.
  function automatic longint unsigned series_exp(longint unsigned r);
    longint          acc;
    longint unsigned term;
    acc  = longint'(ONE_Q32);
    term = ONE_Q32;
    for (int k = 1; k <= 16; k++) begin
      term = q32_mul(term, r) / longint'(k);
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return longint'(acc);
  endfunction

  // e^-t for t with twelve fraction bits: fractional series, then whole units.
  function automatic longint unsigned exp_of_neg(longint unsigned t);
    longint unsigned whole;
    longint unsigned e;
    longint unsigned e_unit;
    whole = t >> FRAC_BITS;
    if (whole >= 24) begin
      return 0;
    end
    e      = series_exp((t & ((64'd1 << FRAC_BITS) - 1)) << (32 - FRAC_BITS));
    e_unit = series_exp(HALF_Q32);
    e_unit = q32_mul(e_unit, e_unit);
    for (longint unsigned i = 0; i < whole; i++) begin
      e = q32_mul(e, e_unit);
    end
    return e;
  endfunction

  function automatic longint rounded_ratio(longint unsigned num, longint unsigned den);
    return longint'(((num << FRAC_BITS) + (den >> 1)) / den);
  endfunction

  function automatic nau_out_t activate(nau_in_t w);
    nau_out_t        r;
    longint          x;
    longint          y;
    longint unsigned mag;
    longint unsigned e;
    x   = longint'(w.sample);
    mag = (x < 0) ? longint'(-x) : longint'(x);
    case (w.mode)
      MODE_RELU: begin
        y = (x < 0) ? 0 : x;
      end
      MODE_SIGMOID: begin
        e = exp_of_neg(mag);
        y = rounded_ratio((x < 0) ? e : ONE_Q32, ONE_Q32 + e);
      end
      MODE_TANH: begin
        e = exp_of_neg(mag << 1);
        y = rounded_ratio(ONE_Q32 - e, ONE_Q32 + e);
        if (x < 0) begin
          y = -y;
        end
      end
      default: begin
        // The unused mode hands the sample through untouched.
        y = x;
      end
    endcase
    if (y > 32767) begin
      y = 32767;
    end
    if (y < -32768) begin
      y = -32768;
    end
    r.activated = DATA_WIDTH'(y);
    r.last_out  = w.last;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic queue_word(input logic [1:0] mode, input logic [15:0] sample,
                            input logic last);
    nau_in_t w;
    w.mode   = mode;
    w.sample = sample;
    w.last   = last;
    pending_words.push_back(w);
  endtask

  // Driver: presents the oldest pending word and retires it once accepted.
  // The word stays on the port until full is seen low at an edge with push
  // high, so each edge decides push exactly once.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      logic accepted;
      accepted = push && !full;
      if (accepted) begin
        expected_results.push_back(activate(in_word));
        void'(pending_words.pop_front());
      end
      if (pending_words.size() > (accepted ? 0 : 0) && !hold_send &&
          ($urandom_range(99) >= send_idle_pct || (push && !accepted))) begin
        push    <= 1'b1;
        in_word <= pending_words[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: checks each popped word against the oldest expectation and
  // picks a fresh stall decision for the next edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", longint'(out_word.activated), 0);
        end else begin
          nau_out_t want;
          want = expected_results.pop_front();
          if (out_word.activated !== want.activated) begin
            report_mismatch("activated", longint'(out_word.activated),
                            longint'(want.activated));
          end
          if (out_word.last_out !== want.last_out) begin
            report_mismatch("last_out", longint'(out_word.last_out),
                            longint'(want.last_out));
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    // A word held back is taken from the queue only when accepted, so an
    // idle edge must never drop a presented word; the driver above keeps
    // push high for a presented word until it goes in.
    push           = 1'b0;
    pop            = 1'b0;
    in_word        = '0;
    rst_n          = 1'b0;
    hold_send      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: field extremes, every mode including the unused one,
    // saturation limits and both last values.
    for (int m = 0; m < 4; m++) begin
      queue_word(m[1:0], 16'h0000, 1'b0);
      queue_word(m[1:0], 16'h7fff, 1'b1);
      queue_word(m[1:0], 16'h8000, 1'b0);
      queue_word(m[1:0], 16'hffff, 1'b1);
    end
    queue_word(MODE_SIGMOID, 16'h1000, 1'b0);
    queue_word(MODE_SIGMOID, 16'hf000, 1'b1);
    queue_word(MODE_TANH, 16'h0800, 1'b0);
    queue_word(MODE_TANH, 16'hf800, 1'b0);
    queue_word(MODE_TANH, 16'h0001, 1'b1);
    queue_word(MODE_SIGMOID, 16'h5555, 1'b0);
    queue_word(MODE_TANH, 16'haaaa, 1'b1);
    wait (pending_words.size() == 0 && expected_results.size() == 0);

    // Random phases under each idling pattern, with a quiet stretch between
    // them during which the sender waits for everything outstanding.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int i = 0; i < 375; i++) begin
        logic [15:0] s;
        // Mostly small magnitudes where the curves bend, some full range.
        s = ($urandom_range(3) == 0) ? 16'($urandom)
                                     : 16'($signed(16'($urandom_range(16383))) - 8192);
        queue_word(($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)), s,
                   1'($urandom));
        if (i == 180) begin
          wait (pending_words.size() == 0);
          hold_send = 1'b1;
          wait (expected_results.size() == 0);
          hold_send = 1'b0;
        end
      end
      wait (pending_words.size() == 0 && expected_results.size() == 0);
    end

    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("neural_activation_unit test passed");
    end else begin
      $display("neural_activation_unit test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("neural_activation_unit test failed");
    $finish;
  end

endmodule
